// ===== rtl/core/rgbyv_pkg.sv =====
// ----------------------------------------------------------------------------
// RGBA to YV12 converter package
// Shared types, register indexes, chroma codes and BT.601 coefficients.
// ----------------------------------------------------------------------------
package rgbyv_pkg;

    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 2;
    localparam int SIZE_W      = 13;
    localparam int OFFSET_W    = 25;
    localparam int PIXEL_W     = 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_WIDTH   = 2'd0,
        REG_FRAME_HEIGHT  = 2'd1,
        REG_REVERSE_ORDER = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CHROMA_NONE = 2'd0,
        CHROMA_U    = 2'd1,
        CHROMA_V    = 2'd2
    } chroma_kind_t;

    localparam logic [SIZE_W-1:0]   RESET_WIDTH  = 13'd640;
    localparam logic [SIZE_W-1:0]   RESET_HEIGHT = 13'd480;
    localparam logic [OFFSET_W-1:0] RESET_AREA   = 25'd307200;

    localparam logic [15:0] Y_COEF_R   = 16'd66;
    localparam logic [15:0] Y_COEF_G   = 16'd129;
    localparam logic [15:0] Y_COEF_B   = 16'd25;
    localparam logic [15:0] ROUND_BIAS = 16'd128;
    localparam logic [7:0]  Y_OFFSET   = 8'd16;
    localparam logic [15:0] U_COEF_R   = 16'd38;
    localparam logic [15:0] U_COEF_G   = 16'd74;
    localparam logic [15:0] UV_COEF_BIG = 16'd112;
    localparam logic [15:0] V_COEF_G   = 16'd94;
    localparam logic [15:0] V_COEF_B   = 16'd18;
    localparam logic [15:0] CHROMA_BIAS = 16'd32896;

    // Clamps a frame dimension to 2..max and rounds it down to even.
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W:0]   maxv);
        logic [SIZE_W:0] t;
        t = {1'b0, v};
        if (t < 14'd2) begin
            t = 14'd2;
        end
        if (t > maxv) begin
            t = maxv;
        end
        t[0] = 1'b0;
        if (t < 14'd2) begin
            t = 14'd2;
        end
        return t[SIZE_W-1:0];
    endfunction

endpackage

// ===== rtl/core/rgba_to_yv12_pixel_converter_core.sv =====
// ----------------------------------------------------------------------------
// RGBA to YV12 pixel converter core
// Converts raster-order RGB pixels to BT.601 luma and point-sampled chroma
// with their byte offsets in a planar Y, V, U buffer.
// ----------------------------------------------------------------------------
// Pixels enter on the s_ channel and one result per pixel leaves on the m_
// channel, both with valid/ready handshakes. Each result carries the luma
// value and its buffer offset, and on even columns a U sample (even rows) or
// a V sample (odd rows) with its offset; otherwise the chroma fields are zero.
// m_frame_last marks the final pixel of a frame, after which the counters and
// plane pointers restart.
// A pixel passes an input register and then a result register before its
// result is presented. One pixel is accepted in every cycle in which the
// result side is not stalled; the throughput is one item per clock.
// When the receiver holds m_ready low, the result register holds its item,
// the input register still takes one more item, and s_ready then drops.
// The configuration port is to be written while the core is idle; the core
// itself does not enforce this. Every write to a known register index
// restarts the frame and recomputes the plane layout.
// A synchronous active-low reset empties both registers and loads a 640 by
// 480 forward frame.
// ----------------------------------------------------------------------------
module rgba_to_yv12_pixel_converter_core #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_write_enable,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_write_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_red,
    input  logic [7:0]  s_green,
    input  logic [7:0]  s_blue,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_luma_value,
    output logic [24:0] m_luma_offset,
    output logic [1:0]  m_chroma_kind,
    output logic [7:0]  m_chroma_value,
    output logic [24:0] m_chroma_offset,
    output logic        m_frame_last
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam logic [13:0] MAX_W_LIM = 14'(MAX_WIDTH);
    localparam logic [13:0] MAX_H_LIM = 14'(MAX_HEIGHT);

    logic        s1_valid_reg;
    logic [7:0]  s1_red_reg;
    logic [7:0]  s1_green_reg;
    logic [7:0]  s1_blue_reg;

    logic [12:0] width_reg, width_next;
    logic [12:0] height_reg, height_next;
    logic        reverse_reg, reverse_next;
    logic [25:0] area_reg, area_next;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             restart_reg, restart_next;
    logic [24:0]      luma_ptr_reg, luma_ptr_next;
    logic [24:0]      u_ptr_reg, u_ptr_next;
    logic [24:0]      v_ptr_reg, v_ptr_next;

    logic        m_valid_reg;
    logic [7:0]  luma_value_reg, luma_value_next;
    logic [24:0] luma_offset_reg, luma_offset_next;
    rgbyv_pkg::chroma_kind_t chroma_kind_reg, chroma_kind_next;
    logic [7:0]  chroma_value_reg, chroma_value_next;
    logic [24:0] chroma_offset_reg, chroma_offset_next;
    logic        frame_last_reg, frame_last_next;

    logic        out_ready;
    logic        s1_advance;
    logic        cfg_known;
    logic [12:0] mult_a, mult_b;
    logic [25:0] product;
    logic [24:0] quarter;
    logic [24:0] luma_start, u_start, v_start;
    logic [24:0] luma_cur, u_cur, v_cur;
    logic [24:0] step_luma, step_u, step_v;
    logic [13:0] col_plus, row_plus;
    logic        col_end, row_end;
    logic [15:0] y_sum, u_sum, v_sum;

    assign out_ready  = !m_valid_reg || m_ready;
    assign s1_advance = s1_valid_reg && out_ready;
    assign s_ready    = !s1_valid_reg || out_ready;

    // Configuration and frame layout.
    always_comb begin
        width_next   = width_reg;
        height_next  = height_reg;
        reverse_next = reverse_reg;
        cfg_known    = 1'b0;
        mult_a       = width_reg;
        mult_b       = height_reg;
        case (rgbyv_pkg::cfg_reg_t'(cfg_index))
            rgbyv_pkg::REG_FRAME_WIDTH: begin
                cfg_known = 1'b1;
                mult_a    = rgbyv_pkg::eff_size(cfg_write_data, MAX_W_LIM);
            end
            rgbyv_pkg::REG_FRAME_HEIGHT: begin
                cfg_known = 1'b1;
                mult_b    = rgbyv_pkg::eff_size(cfg_write_data, MAX_H_LIM);
            end
            rgbyv_pkg::REG_REVERSE_ORDER: begin
                cfg_known = 1'b1;
            end
            default: begin
                cfg_known = 1'b0;
            end
        endcase
        product   = 26'(mult_a) * 26'(mult_b);
        area_next = area_reg;
        if (cfg_write_enable && cfg_known) begin
            width_next  = mult_a;
            height_next = mult_b;
            area_next   = product;
            if (rgbyv_pkg::cfg_reg_t'(cfg_index) == rgbyv_pkg::REG_REVERSE_ORDER) begin
                reverse_next = cfg_write_data[0];
            end
        end
    end

    // Color conversion, plane pointers and raster counters.
    always_comb begin
        quarter = {1'b0, area_reg[25:2]};
        if (reverse_reg) begin
            luma_start = area_reg[24:0] - 25'd1;
            v_start    = area_reg[24:0] + quarter - 25'd1;
            u_start    = area_reg[24:0] + {quarter[23:0], 1'b0} - 25'd1;
            step_luma  = '1;
        end else begin
            luma_start = '0;
            v_start    = area_reg[24:0];
            u_start    = area_reg[24:0] + quarter;
            step_luma  = 25'd1;
        end
        step_u = step_luma;
        step_v = step_luma;

        luma_cur = restart_reg ? luma_start : luma_ptr_reg;
        u_cur    = restart_reg ? u_start : u_ptr_reg;
        v_cur    = restart_reg ? v_start : v_ptr_reg;

        y_sum = rgbyv_pkg::Y_COEF_R * 16'(s1_red_reg) + rgbyv_pkg::Y_COEF_G * 16'(s1_green_reg)
              + rgbyv_pkg::Y_COEF_B * 16'(s1_blue_reg) + rgbyv_pkg::ROUND_BIAS;
        u_sum = rgbyv_pkg::UV_COEF_BIG * 16'(s1_blue_reg) + rgbyv_pkg::CHROMA_BIAS
              - rgbyv_pkg::U_COEF_R * 16'(s1_red_reg) - rgbyv_pkg::U_COEF_G * 16'(s1_green_reg);
        v_sum = rgbyv_pkg::UV_COEF_BIG * 16'(s1_red_reg) + rgbyv_pkg::CHROMA_BIAS
              - rgbyv_pkg::V_COEF_G * 16'(s1_green_reg) - rgbyv_pkg::V_COEF_B * 16'(s1_blue_reg);

        luma_value_next    = y_sum[15:8] + rgbyv_pkg::Y_OFFSET;
        luma_offset_next   = luma_cur;
        chroma_kind_next   = rgbyv_pkg::CHROMA_NONE;
        chroma_value_next  = '0;
        chroma_offset_next = '0;
        luma_ptr_next      = luma_cur + step_luma;
        u_ptr_next         = u_cur;
        v_ptr_next         = v_cur;
        if (!col_reg[0]) begin
            if (!row_reg[0]) begin
                chroma_kind_next   = rgbyv_pkg::CHROMA_U;
                chroma_value_next  = u_sum[15:8];
                chroma_offset_next = u_cur;
                u_ptr_next         = u_cur + step_u;
            end else begin
                chroma_kind_next   = rgbyv_pkg::CHROMA_V;
                chroma_value_next  = v_sum[15:8];
                chroma_offset_next = v_cur;
                v_ptr_next         = v_cur + step_v;
            end
        end

        col_plus        = 14'(col_reg) + 14'd1;
        row_plus        = 14'(row_reg) + 14'd1;
        col_end         = col_plus >= {1'b0, width_reg};
        row_end         = row_plus >= {1'b0, height_reg};
        frame_last_next = col_end && row_end;

        restart_next = 1'b0;
        col_next     = col_plus[COL_W-1:0];
        row_next     = row_reg;
        if (frame_last_next) begin
            restart_next = 1'b1;
            col_next     = '0;
            row_next     = '0;
        end else if (col_end) begin
            col_next = '0;
            row_next = row_plus[ROW_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            width_reg    <= rgbyv_pkg::RESET_WIDTH;
            height_reg   <= rgbyv_pkg::RESET_HEIGHT;
            reverse_reg  <= 1'b0;
            area_reg     <= {1'b0, rgbyv_pkg::RESET_AREA};
            col_reg      <= '0;
            row_reg      <= '0;
            restart_reg  <= 1'b1;
        end else begin
            if (s_ready) begin
                s1_valid_reg <= s_valid;
            end
            if (out_ready) begin
                m_valid_reg <= s1_valid_reg;
            end
            width_reg   <= width_next;
            height_reg  <= height_next;
            reverse_reg <= reverse_next;
            area_reg    <= area_next;
            if (cfg_write_enable && cfg_known) begin
                col_reg     <= '0;
                row_reg     <= '0;
                restart_reg <= 1'b1;
            end else if (s1_advance) begin
                col_reg     <= col_next;
                row_reg     <= row_next;
                restart_reg <= restart_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            s1_red_reg   <= s_red;
            s1_green_reg <= s_green;
            s1_blue_reg  <= s_blue;
        end
        if (s1_advance) begin
            luma_ptr_reg      <= luma_ptr_next;
            u_ptr_reg         <= u_ptr_next;
            v_ptr_reg         <= v_ptr_next;
            luma_value_reg    <= luma_value_next;
            luma_offset_reg   <= luma_offset_next;
            chroma_kind_reg   <= chroma_kind_next;
            chroma_value_reg  <= chroma_value_next;
            chroma_offset_reg <= chroma_offset_next;
            frame_last_reg    <= frame_last_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_luma_value    = luma_value_reg;
    assign m_luma_offset   = luma_offset_reg;
    assign m_chroma_kind   = chroma_kind_reg;
    assign m_chroma_value  = chroma_value_reg;
    assign m_chroma_offset = chroma_offset_reg;
    assign m_frame_last    = frame_last_reg;

endmodule

// ===== rtl/core/rgbyv_checker.sv =====
// ----------------------------------------------------------------------------
// RGBA to YV12 converter port checker
// Watches the result channel of the converter core over time.
// ----------------------------------------------------------------------------
module rgbyv_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_luma_value,
    input logic [24:0] m_luma_offset,
    input logic [1:0]  m_chroma_kind,
    input logic [7:0]  m_chroma_value,
    input logic [24:0] m_chroma_offset
);

    // No result may be presented in the cycle after reset.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_luma_offset)
            && $stable(m_chroma_offset))
        else $error("stalled item changed");

    // A pixel without a chroma sample reports zero chroma fields.
    a_no_chroma_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_chroma_kind == rgbyv_pkg::CHROMA_NONE
            |-> m_chroma_value == 8'd0 && m_chroma_offset == 25'd0)
        else $error("chroma fields set without a sample");

    a_value_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_luma_value >= 8'd16 && m_luma_value <= 8'd235
            && (m_chroma_kind == rgbyv_pkg::CHROMA_NONE
                || (m_chroma_value >= 8'd16 && m_chroma_value <= 8'd240)))
        else $error("luma or chroma out of range");

endmodule

bind rgba_to_yv12_pixel_converter_core rgbyv_checker u_rgbyv_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_luma_value    (m_luma_value),
    .m_luma_offset   (m_luma_offset),
    .m_chroma_kind   (m_chroma_kind),
    .m_chroma_value  (m_chroma_value),
    .m_chroma_offset (m_chroma_offset)
);
